>>> src/mmh64_pkg.sv
// Shared types and constants for the streaming MurmurHash64A block.
// Used by the controller, the datapath and the top level; depends on nothing.
package mmh64_pkg;

	localparam logic [63:0] MIX_MUL              = 64'hc6a4a7935bd1e995;
	localparam int unsigned MIX_SHIFT            = 47;
	localparam logic [63:0] SEED_PRIMARY_RESET   = 64'h9ae16a3b2f90404f;
	localparam logic [63:0] SEED_SECONDARY_RESET = 64'h85ebca6b85ebca6b;

	localparam int unsigned CFG_INDEX_W = 1;
	localparam logic [CFG_INDEX_W-1:0] REG_PRIMARY_SEED   = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_SECONDARY_SEED = 1'b1;

	typedef struct packed {
		logic [63:0] word;
		logic [3:0]  byte_count;
		logic        first_word;
		logic        last_word;
		logic [31:0] total_length;
	} in_t;

	typedef struct packed {
		logic [63:0] hash_primary;
		logic [63:0] hash_secondary;
	} out_t;

	// Operand chosen for the multiplier's input register.
	typedef enum logic [3:0] {
		X_LEN,
		X_WORD,
		X_KMIX,
		X_HPK,
		X_HSK,
		X_HPT,
		X_HST,
		X_HPF,
		X_HSF
	} xsel_t;

	// Register write performed when a product is complete.
	typedef enum logic [2:0] {
		W_NONE,
		W_SEED,
		W_K,
		W_P_ACC,
		W_S_ACC,
		W_P_FIN,
		W_S_FIN
	} wr_t;

	// Partial-product step of the shared 32 x 32 multiplier.
	typedef enum logic [1:0] {
		M_A,
		M_B,
		M_C
	} mstep_t;

	typedef struct packed {
		logic   capture;
		logic   load_x;
		xsel_t  xsel;
		logic   mul_en;
		mstep_t mstep;
		wr_t    wr;
		logic   load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic first;
		logic last;
		logic full;
		logic empty;
	} dp_status_t;

endpackage

>>> src/mmh64_dp.sv
// Datapath: seed registers, both running hashes, the shared multiplier and
// the result register. Driven by mmh64_ctrl; depends on mmh64_pkg.
module mmh64_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [mmh64_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [63:0]                          cfg_data,
	input  mmh64_pkg::in_t                       in_data,
	input  mmh64_pkg::dp_cmd_t                   cmd,
	output mmh64_pkg::dp_status_t                status,
	output mmh64_pkg::out_t                      out_data
);

	logic [63:0]          seed_p_q;
	logic [63:0]          seed_s_q;
	mmh64_pkg::in_t       item_q;
	logic [63:0]          hp_q;
	logic [63:0]          hs_q;
	logic [63:0]          k_q;
	logic [63:0]          x_q;
	logic [63:0]          acc_q;
	mmh64_pkg::out_t      out_q;

	logic [63:0] tail;
	logic [63:0] acc_mix;
	logic [63:0] x_d;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] prod;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_p_q <= mmh64_pkg::SEED_PRIMARY_RESET;
			seed_s_q <= mmh64_pkg::SEED_SECONDARY_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mmh64_pkg::REG_PRIMARY_SEED:   seed_p_q <= cfg_data;
				mmh64_pkg::REG_SECONDARY_SEED: seed_s_q <= cfg_data;
			endcase
		end
	end

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			tail[i*8 +: 8] = (4'(i) < item_q.byte_count) ? item_q.word[i*8 +: 8] : 8'h00;
		end
	end

	assign acc_mix = acc_q ^ (acc_q >> mmh64_pkg::MIX_SHIFT);

	always_comb begin
		unique case (cmd.xsel)
			mmh64_pkg::X_LEN:  x_d = {32'h0, item_q.total_length};
			mmh64_pkg::X_WORD: x_d = item_q.word;
			mmh64_pkg::X_KMIX: x_d = acc_mix;
			mmh64_pkg::X_HPK:  x_d = hp_q ^ acc_q;
			mmh64_pkg::X_HSK:  x_d = hs_q ^ k_q;
			mmh64_pkg::X_HPT:  x_d = hp_q ^ tail;
			mmh64_pkg::X_HST:  x_d = hs_q ^ tail;
			mmh64_pkg::X_HPF:  x_d = hp_q ^ (hp_q >> mmh64_pkg::MIX_SHIFT);
			mmh64_pkg::X_HSF:  x_d = hs_q ^ (hs_q >> mmh64_pkg::MIX_SHIFT);
			default:           x_d = item_q.word;
		endcase
	end

	// The low 64 bits of x * MIX_MUL are built from three 32 x 32 partial products.
	assign mul_a = (cmd.mstep == mmh64_pkg::M_C) ? x_q[63:32] : x_q[31:0];
	assign mul_b = (cmd.mstep == mmh64_pkg::M_B) ? mmh64_pkg::MIX_MUL[63:32]
	                                             : mmh64_pkg::MIX_MUL[31:0];
	assign prod  = {32'h0, mul_a} * {32'h0, mul_b};

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= in_data;
		end
		if (cmd.load_x) begin
			x_q <= x_d;
		end
		if (cmd.mul_en) begin
			if (cmd.mstep == mmh64_pkg::M_A) begin
				acc_q <= prod;
			end else begin
				acc_q <= acc_q + {prod[31:0], 32'h0};
			end
		end
		unique case (cmd.wr)
			mmh64_pkg::W_SEED: begin
				hp_q <= seed_p_q ^ acc_q;
				hs_q <= seed_s_q ^ acc_q;
			end
			mmh64_pkg::W_K:     k_q  <= acc_q;
			mmh64_pkg::W_P_ACC: hp_q <= acc_q;
			mmh64_pkg::W_S_ACC: hs_q <= acc_q;
			mmh64_pkg::W_P_FIN: hp_q <= acc_mix;
			mmh64_pkg::W_S_FIN: hs_q <= acc_mix;
			default: begin
			end
		endcase
		if (cmd.load_out) begin
			out_q.hash_primary   <= hp_q;
			out_q.hash_secondary <= hs_q;
			hp_q                 <= 64'h0;
			hs_q                 <= 64'h0;
		end
	end

	assign status.first = item_q.first_word;
	assign status.last  = item_q.last_word;
	assign status.full  = item_q.byte_count[3];
	assign status.empty = (item_q.byte_count == 4'h0);
	assign out_data     = out_q;

endmodule

>>> src/mmh64_ctrl.sv
// Controller: sequences the shared multiplier through seeding, word mixing,
// tail mixing and finalisation, and owns both handshakes. Depends on mmh64_pkg.
module mmh64_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	input  mmh64_pkg::dp_status_t status,
	output mmh64_pkg::dp_cmd_t    cmd
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_MUL  = 4'b0010,
		S_POST = 4'b0100,
		S_EMIT = 4'b1000
	} state_t;

	typedef enum logic [3:0] {
		J_START,
		J_LEN,
		J_BODY,
		J_K1,
		J_K2,
		J_HP,
		J_HS,
		J_TP,
		J_TS,
		J_FP,
		J_FS
	} job_t;

	state_t            state_q, state_d;
	job_t              job_q, job_d;
	mmh64_pkg::mstep_t mstep_q, mstep_d;
	logic              in_msg_q, in_msg_d;
	logic              out_valid_q, out_valid_d;

	logic              start_mul;
	mmh64_pkg::xsel_t  nx;
	job_t              nj;
	mmh64_pkg::xsel_t  body_x;
	job_t              body_j;

	always_comb begin
		if (!status.last || status.full) begin
			body_x = mmh64_pkg::X_WORD;
			body_j = J_K1;
		end else if (status.empty) begin
			body_x = mmh64_pkg::X_HPF;
			body_j = J_FP;
		end else begin
			body_x = mmh64_pkg::X_HPT;
			body_j = J_TP;
		end
	end

	always_comb begin
		state_d     = state_q;
		job_d       = job_q;
		mstep_d     = mstep_q;
		in_msg_d    = in_msg_q;
		out_valid_d = out_valid_q & ~out_ready;
		start_mul   = 1'b0;
		nx          = mmh64_pkg::X_WORD;
		nj          = J_START;

		cmd.capture  = 1'b0;
		cmd.load_x   = 1'b0;
		cmd.xsel     = mmh64_pkg::X_WORD;
		cmd.mul_en   = 1'b0;
		cmd.mstep    = mstep_q;
		cmd.wr       = mmh64_pkg::W_NONE;
		cmd.load_out = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					job_d       = J_START;
					state_d     = S_POST;
				end
			end
			S_MUL: begin
				cmd.mul_en = 1'b1;
				unique case (mstep_q)
					mmh64_pkg::M_A: mstep_d = mmh64_pkg::M_B;
					mmh64_pkg::M_B: mstep_d = mmh64_pkg::M_C;
					mmh64_pkg::M_C: state_d = S_POST;
					default:        state_d = S_POST;
				endcase
			end
			S_POST: begin
				unique case (job_q)
					J_START: begin
						if (status.first) begin
							start_mul = 1'b1;
							nx        = mmh64_pkg::X_LEN;
							nj        = J_LEN;
						end else if (!in_msg_q) begin
							state_d = S_IDLE;
						end else begin
							start_mul = 1'b1;
							nx        = body_x;
							nj        = body_j;
						end
					end
					J_LEN: begin
						cmd.wr   = mmh64_pkg::W_SEED;
						in_msg_d = 1'b1;
						job_d    = J_BODY;
					end
					J_BODY: begin
						start_mul = 1'b1;
						nx        = body_x;
						nj        = body_j;
					end
					J_K1: begin
						start_mul = 1'b1;
						nx        = mmh64_pkg::X_KMIX;
						nj        = J_K2;
					end
					J_K2: begin
						cmd.wr    = mmh64_pkg::W_K;
						start_mul = 1'b1;
						nx        = mmh64_pkg::X_HPK;
						nj        = J_HP;
					end
					J_HP: begin
						cmd.wr    = mmh64_pkg::W_P_ACC;
						start_mul = 1'b1;
						nx        = mmh64_pkg::X_HSK;
						nj        = J_HS;
					end
					J_HS: begin
						cmd.wr = mmh64_pkg::W_S_ACC;
						if (status.last) begin
							start_mul = 1'b1;
							nx        = mmh64_pkg::X_HPF;
							nj        = J_FP;
						end else begin
							state_d = S_IDLE;
						end
					end
					J_TP: begin
						cmd.wr    = mmh64_pkg::W_P_ACC;
						start_mul = 1'b1;
						nx        = mmh64_pkg::X_HST;
						nj        = J_TS;
					end
					J_TS: begin
						cmd.wr    = mmh64_pkg::W_S_ACC;
						start_mul = 1'b1;
						nx        = mmh64_pkg::X_HPF;
						nj        = J_FP;
					end
					J_FP: begin
						cmd.wr    = mmh64_pkg::W_P_FIN;
						start_mul = 1'b1;
						nx        = mmh64_pkg::X_HSF;
						nj        = J_FS;
					end
					J_FS: begin
						cmd.wr  = mmh64_pkg::W_S_FIN;
						state_d = S_EMIT;
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_EMIT: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					out_valid_d  = 1'b1;
					in_msg_d     = 1'b0;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase

		if (start_mul) begin
			cmd.load_x = 1'b1;
			cmd.xsel   = nx;
			job_d      = nj;
			mstep_d    = mmh64_pkg::M_A;
			state_d    = S_MUL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			job_q       <= J_START;
			mstep_q     <= mmh64_pkg::M_A;
			in_msg_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			job_q       <= job_d;
			mstep_q     <= mstep_d;
			in_msg_q    <= in_msg_d;
			out_valid_q <= out_valid_d;
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

endmodule

>>> src/murmur64a_hash_stream.sv
// Top level of the streaming MurmurHash64A block with two seeded lanes.
// Instantiates mmh64_ctrl and mmh64_dp; depends on mmh64_pkg.
//
// Each input beat carries one little-endian 64-bit message word; the first beat of a
// message seeds both lanes from the seed registers and total_length, and the last
// beat produces one output beat holding both finished hashes. All products go
// through a single 32 x 32 multiplier: a 64-bit multiply by the mixing constant runs
// through steps M_A, M_B and M_C, then its result is stored as the next operand is
// selected. A middle word is multiplied, then the mixed k, then each lane xored with
// k; no new beat is taken until the current one is done. A first beat adds the
// length multiply for seeding, a last beat the finaliser and the hand-over to the
// output register (a partial tail mixes each lane with the tail instead, an empty
// tail skips it). The output register lets the next message start while a result waits.
module murmur64a_hash_stream (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [mmh64_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [63:0]                        cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  mmh64_pkg::in_t                     in_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output mmh64_pkg::out_t                    out_data
);

	mmh64_pkg::dp_cmd_t    cmd;
	mmh64_pkg::dp_status_t status;

	mmh64_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	mmh64_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.status    (status),
		.out_data  (out_data)
	);

endmodule

>>> sim/murmur64a_hash_stream_tb.sv
// Self-checking testbench for murmur64a_hash_stream: drives message beats and seed writes,
// predicts both lane hashes in its own model and checks every result beat in order.
// Depends on mmh64_pkg and the murmur64a_hash_stream RTL only.
module murmur64a_hash_stream_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mmh64_pkg::*;

	localparam int unsigned QUIET_CYCLES = 64;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [63:0]            cfg_data;
	logic                   in_valid;
	logic                   in_ready;
	in_t                    in_data;
	logic                   out_valid;
	logic                   out_ready;
	out_t                   out_data;

	logic [63:0] seed_primary;
	logic [63:0] seed_secondary;
	logic [63:0] lane_primary;
	logic [63:0] lane_secondary;
	bit          msg_open;
	out_t        expected_hashes[$];
	out_t        oldest_hash;

	int unsigned mismatches      = 0;
	int unsigned hashed_words    = 0;
	int unsigned stray_words     = 0;
	int unsigned messages_done   = 0;
	int unsigned results_checked = 0;
	int unsigned seed_writes     = 0;
	int unsigned hold_off_cycles = 0;
	bit          idling_on       = 1'b1;

	murmur64a_hash_stream u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic logic [63:0] absorb_word(input logic [63:0] h, input logic [63:0] k);
		k = k * MIX_MUL;
		k = k ^ (k >> MIX_SHIFT);
		k = k * MIX_MUL;
		return (h ^ k) * MIX_MUL;
	endfunction

	function automatic logic [63:0] finalise_lane(input logic [63:0] h);
		h = h ^ (h >> MIX_SHIFT);
		h = h * MIX_MUL;
		return h ^ (h >> MIX_SHIFT);
	endfunction

	function automatic void predict_beat(input in_t b);
		logic [63:0] len_mix;
		logic [63:0] tail;
		int unsigned n;
		out_t        res;
		if (b.first_word) begin
			len_mix = {32'd0, b.total_length} * MIX_MUL;
			lane_primary = seed_primary ^ len_mix;
			lane_secondary = seed_secondary ^ len_mix;
			msg_open = 1'b1;
		end
		if (!msg_open) begin
			stray_words++;
			return;
		end
		hashed_words++;
		if (!b.last_word) begin
			lane_primary = absorb_word(lane_primary, b.word);
			lane_secondary = absorb_word(lane_secondary, b.word);
			return;
		end
		n = (b.byte_count > 4'd8) ? 8 : b.byte_count;
		if (n == 8) begin
			lane_primary = absorb_word(lane_primary, b.word);
			lane_secondary = absorb_word(lane_secondary, b.word);
		end else if (n != 0) begin
			tail = b.word & ((64'd1 << (8 * n)) - 64'd1);
			lane_primary = (lane_primary ^ tail) * MIX_MUL;
			lane_secondary = (lane_secondary ^ tail) * MIX_MUL;
		end
		res.hash_primary = finalise_lane(lane_primary);
		res.hash_secondary = finalise_lane(lane_secondary);
		expected_hashes.push_back(res);
		lane_primary = '0;
		lane_secondary = '0;
		msg_open = 1'b0;
		messages_done++;
	endfunction

	function automatic in_t make_beat(input logic [63:0] word, input logic [3:0] byte_count,
			input logic first_word, input logic last_word, input logic [31:0] total_length);
		in_t b;
		b.word = word;
		b.byte_count = byte_count;
		b.first_word = first_word;
		b.last_word = last_word;
		b.total_length = total_length;
		return b;
	endfunction

	function automatic logic [63:0] random_word();
		case ($urandom_range(0, 15))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic send_beat(input in_t b);
		if (idling_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_beat(b);
	endtask

	task automatic send_message(input int unsigned n_full, input logic [3:0] tail_count,
			input bit close);
		in_t         b;
		int unsigned i;
		int unsigned tail_bytes;
		tail_bytes = (tail_count > 4'd8) ? 8 : tail_count;
		for (i = 0; i <= n_full; i++) begin
			b.word = random_word();
			b.first_word = (i == 0);
			b.last_word = close && (i == n_full);
			if (b.last_word)
				b.byte_count = tail_count;
			else if ($urandom_range(0, 3) == 0)
				b.byte_count = 4'($urandom_range(0, 15));
			else
				b.byte_count = 4'd8;
			if (i == 0 && $urandom_range(0, 7) != 0)
				b.total_length = 32'(n_full * 8 + tail_bytes);
			else
				b.total_length = $urandom;
			send_beat(b);
		end
	endtask

	task automatic send_stray();
		send_beat(make_beat(random_word(), 4'($urandom_range(0, 15)), 1'b0,
			1'($urandom_range(0, 1)), $urandom));
	endtask

	task automatic wait_quiet();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_hashes.size() != 0) @(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic write_seed(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] value);
		wait_quiet();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_PRIMARY_SEED)
			seed_primary = value;
		else
			seed_secondary = value;
		seed_writes++;
	endtask

	task automatic test_single_beat_messages();
		send_beat(make_beat('0, 4'd0, 1'b1, 1'b1, 32'd0));
		send_beat(make_beat('1, 4'd8, 1'b1, 1'b1, 32'hffff_ffff));
		send_beat(make_beat(random_word(), 4'd3, 1'b1, 1'b1, 32'd3));
		send_beat(make_beat(random_word(), 4'd15, 1'b1, 1'b1, 32'd8));
		send_beat(make_beat('1, 4'd7, 1'b1, 1'b1, 32'd7));
	endtask

	task automatic test_stray_beats();
		send_beat(make_beat(random_word(), 4'd8, 1'b0, 1'b0, $urandom));
		send_beat(make_beat(random_word(), 4'd8, 1'b0, 1'b1, $urandom));
		send_message(1, 4'd8, 1'b1);
	endtask

	task automatic test_abandoned_message();
		send_beat(make_beat(random_word(), 4'd3, 1'b1, 1'b0, 32'd13));
		send_beat(make_beat(random_word(), 4'd0, 1'b0, 1'b0, $urandom));
		send_message(1, 4'd5, 1'b1);
	endtask

	task automatic test_tail_lengths();
		send_message(1, 4'd0, 1'b1);
		send_message(1, 4'd1, 1'b1);
		send_message(1, 4'd7, 1'b1);
		send_message(1, 4'd8, 1'b1);
	endtask

	task automatic test_seed_settings();
		write_seed(REG_PRIMARY_SEED, '0);
		write_seed(REG_SECONDARY_SEED, '0);
		send_message(1, 4'd4, 1'b1);
		write_seed(REG_PRIMARY_SEED, '1);
		write_seed(REG_SECONDARY_SEED, '1);
		send_message(0, 4'd8, 1'b1);
		write_seed(REG_PRIMARY_SEED, {$urandom, $urandom});
		write_seed(REG_SECONDARY_SEED, {$urandom, $urandom});
		send_message(1, 4'd2, 1'b1);
	endtask

	// The receiver stops taking results while messages keep arriving, so the
	// output register fills and the block must hold off its input.
	task automatic test_output_stall();
		wait_quiet();
		hold_off_cycles = 400;
		repeat (10) send_message($urandom_range(0, 1), 4'($urandom_range(0, 15)), 1'b1);
	endtask

	task automatic test_random_traffic(input int unsigned beats);
		int unsigned start;
		int unsigned pick;
		int unsigned n_full;
		start = hashed_words;
		while (hashed_words - start < beats) begin
			pick = $urandom_range(0, 99);
			n_full = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
			if (pick < 80)
				send_message(n_full, 4'($urandom_range(0, 15)), 1'b1);
			else if (pick < 92)
				send_message(n_full, 4'd0, 1'b0);
			else if (!msg_open)
				repeat ($urandom_range(1, 3)) send_stray();
		end
		send_message($urandom_range(0, 3), 4'($urandom_range(0, 15)), 1'b1);
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_PRIMARY_SEED;
		cfg_data <= '0;
		in_valid <= 1'b0;
		in_data <= '0;
		seed_primary = SEED_PRIMARY_RESET;
		seed_secondary = SEED_SECONDARY_RESET;
		lane_primary = '0;
		lane_secondary = '0;
		msg_open = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_single_beat_messages();
		test_stray_beats();
		test_abandoned_message();
		test_tail_lengths();
		test_seed_settings();
		test_output_stall();
		test_random_traffic(650);
		write_seed(REG_PRIMARY_SEED, {$urandom, $urandom});
		write_seed(REG_SECONDARY_SEED, {$urandom, $urandom});
		test_random_traffic(550);
		wait_quiet();
		idling_on = 1'b0;
		test_random_traffic(550);
		wait_quiet();

		$display("Run covered %0d hashed words in %0d messages, %0d ignored stray words and %0d seed writes.",
			hashed_words, messages_done, stray_words, seed_writes);
		$display("%0d result beats were checked with %0d mismatches.", results_checked, mismatches);
		if (mismatches == 0)
			$display("murmur64a_hash_stream_tb OK");
		else
			$display("murmur64a_hash_stream_tb NOT OK");
		$finish;
	end

	initial begin
		out_ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_off_cycles != 0) begin
				out_ready <= 1'b0;
				repeat (hold_off_cycles) @(posedge clk);
				hold_off_cycles = 0;
			end else if (idling_on && $urandom_range(0, 2) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 40)) @(posedge clk);
			end
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (expected_hashes.size() == 0) begin
					$error("result beat with no message pending: %h", out_data);
					mismatches++;
				end else begin
					oldest_hash = expected_hashes.pop_front();
					results_checked++;
					if (out_data.hash_primary !== oldest_hash.hash_primary) begin
						$error("hash_primary: expected %h, got %h",
							oldest_hash.hash_primary, out_data.hash_primary);
						mismatches++;
					end
					if (out_data.hash_secondary !== oldest_hash.hash_secondary) begin
						$error("hash_secondary: expected %h, got %h",
							oldest_hash.hash_secondary, out_data.hash_secondary);
						mismatches++;
					end
				end
			end
		end
	end

	initial begin
		#8_000_000;
		$display("murmur64a_hash_stream_tb NOT OK");
		$finish;
	end

endmodule
